/* hw/rtl/set_assoc_cache_lru_sim_assert.svh */
// Assertion macros for the cache tag store model.
`ifndef SET_ASSOC_CACHE_LRU_SIM_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_SIM_ASSERT_SVH
`ifndef SYNTHESIS
`define SALRU_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("salru: implication check failed");
`define SALRU_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("salru: next-cycle check failed");
`else
`define SALRU_ASSERT_IMP(name, ante, cons)
`define SALRU_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* hw/rtl/salru_pkg.sv */
// Shared widths, codes and defaults of the cache tag store model.
package salru_pkg;
	localparam int ACTION_W     = 2;
	localparam int ADDRESS_W    = 64;
	localparam int OUTCOME_W    = 2;
	localparam int COUNT_W      = 32;
	localparam int AGE_W        = 3;
	localparam int SET_BITS_W   = 4;
	localparam int WAYS_W       = 4;
	localparam int BLOCK_BITS_W = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 5;

	localparam int MAX_SET_BITS_DEF = 10;
	localparam int MAX_WAYS_DEF     = 8;
	localparam int ADDR_WIDTH_DEF   = 64;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

	localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;

	localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

	localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
	localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
	localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
endpackage

/* hw/rtl/salru_if.sv */
// Valid/ready channel interfaces for access requests and access results.
interface salru_req_if;
	logic                               valid;
	logic                               ready;
	logic [salru_pkg::ACTION_W-1:0]     action;
	logic [salru_pkg::ADDRESS_W-1:0]    address;

	modport source (output valid, output action, output address, input ready);
	modport sink (input valid, input action, input address, output ready);
endinterface

interface salru_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [salru_pkg::OUTCOME_W-1:0]    outcome;
	logic                               second_hit;
	logic [salru_pkg::COUNT_W-1:0]      hit_total;
	logic [salru_pkg::COUNT_W-1:0]      miss_total;
	logic [salru_pkg::COUNT_W-1:0]      evict_total;

	modport source (output valid, output outcome, output second_hit, output hit_total,
		output miss_total, output evict_total, input ready);
	modport sink (input valid, input outcome, input second_hit, input hit_total,
		input miss_total, input evict_total, output ready);
endinterface

/* hw/rtl/set_assoc_cache_lru_sim.sv */
// Tag store of a set-associative cache with LRU replacement and hit/miss counters.
//
// Usage: access items arrive on req (action, address) under valid/ready; one result
// item per access leaves on rsp (outcome, second_hit and the three running totals).
// Configuration (set_bits, ways, block_bits) is written through cfg_we/cfg_index/
// cfg_data while the block is idle; the store is not flushed by a write.
// Each set is one row of a synchronous RAM holding valid bit, tag and age of every way.
// For each item the accept cycle reads the set row; the lookup state then compares
// the ways, writes the updated row back and loads the result register. A new item is
// taken only once the current one has written its row back, so the read-modify-write
// of the set-row memory is never overlapped. A modify needs no second lookup: its
// second access always hits the line just touched and leaves the ages as they are.
// After reset the block runs a clearing pass that zeroes all 2**MAX_SET_BITS rows
// (1024 with the default); req.ready stays low meanwhile, configuration writes are
// taken as usual. Counters and registers return to their reset values.
// When the receiver stalls, the result stays in the output register and the block
// still accepts one more item; that item waits in its compare cycle until the
// output register frees up.
module set_assoc_cache_lru_sim #(
	parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = salru_pkg::MAX_WAYS_DEF,
	parameter int ADDR_WIDTH   = salru_pkg::ADDR_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	salru_req_if.sink                          req,
	salru_rsp_if.source                        rsp,
	input  logic                               cfg_we,
	input  logic [salru_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [salru_pkg::CFG_DATA_W-1:0]   cfg_data
);
	`include "set_assoc_cache_lru_sim_assert.svh"

	localparam int SET_W     = MAX_SET_BITS;
	localparam int SETS      = 1 << SET_W;
	localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NW_W      = $clog2(MAX_WAYS + 1);
	localparam int SB_W      = $clog2(MAX_SET_BITS + 1);
	localparam int AGE_W     = salru_pkg::AGE_W;
	localparam int LIM_W     = AGE_W + 1;
	localparam int SHIFT_W   = $clog2((1 << salru_pkg::BLOCK_BITS_W) + MAX_SET_BITS);
	localparam int LINE_W    = 1 + ADDR_WIDTH + AGE_W;
	localparam int ROW_W     = MAX_WAYS * LINE_W;
	localparam int COUNT_W   = salru_pkg::COUNT_W;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

	logic [1:0]                            st_q;
	logic [SET_W-1:0]                      clr_q;
	logic [salru_pkg::SET_BITS_W-1:0]      set_bits_q;
	logic [salru_pkg::WAYS_W-1:0]          ways_q;
	logic [salru_pkg::BLOCK_BITS_W-1:0]    block_bits_q;

	logic [SET_W-1:0]                      set_s1;
	logic [ADDR_WIDTH-1:0]                 tag_s1;
	logic                                  modify_s1;

	logic                                  rsp_valid_q;
	logic [salru_pkg::OUTCOME_W-1:0]       outcome_q;
	logic                                  second_hit_q;
	logic [COUNT_W-1:0]                    hits_q;
	logic [COUNT_W-1:0]                    misses_q;
	logic [COUNT_W-1:0]                    evicts_q;

	logic [SB_W-1:0]                       sb_eff;
	logic [NW_W-1:0]                       nw_eff;
	logic [SET_W-1:0]                      set_mask;
	logic [ADDR_WIDTH-1:0]                 addr_a;
	logic [SET_W-1:0]                      set_in;
	logic [ADDR_WIDTH-1:0]                 tag_in;
	logic                                  accept;
	logic                                  out_free;
	logic                                  commit;

	logic                                  ram_we;
	logic [SET_W-1:0]                      ram_waddr;
	logic [ROW_W-1:0]                      ram_wdata;
	logic [ROW_W-1:0]                      ram_rdata;
	logic [ROW_W-1:0]                      row_new;

	logic [MAX_WAYS-1:0]                   vld;
	logic [MAX_WAYS-1:0]                   in_use;
	logic [ADDR_WIDTH-1:0]                 tags [MAX_WAYS];
	logic [AGE_W-1:0]                      ages [MAX_WAYS];
	logic                                  hit;
	logic                                  empty;
	logic [WAY_IDX_W-1:0]                  hit_way;
	logic [WAY_IDX_W-1:0]                  empty_way;
	logic [WAY_IDX_W-1:0]                  victim_way;
	logic [AGE_W-1:0]                      victim_age;
	logic [WAY_IDX_W-1:0]                  touched_way;
	logic [LIM_W-1:0]                      age_limit;
	logic [1:0]                            hit_inc;
	logic [COUNT_W:0]                      hits_sum;
	logic [COUNT_W:0]                      misses_sum;
	logic [COUNT_W:0]                      evicts_sum;

	// Effective configuration with out-of-range values clamped.
	assign sb_eff = (32'(set_bits_q) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits_q);
	assign nw_eff = (ways_q == '0) ? NW_W'(1) :
		((32'(ways_q) > MAX_WAYS) ? NW_W'(MAX_WAYS) : NW_W'(ways_q));
	assign set_mask = ~({SET_W{1'b1}} << sb_eff);

	assign addr_a = req.address[ADDR_WIDTH-1:0];
	assign set_in = SET_W'(addr_a >> block_bits_q) & set_mask;
	assign tag_in = addr_a >> (SHIFT_W'(block_bits_q) + SHIFT_W'(sb_eff));

	assign req.ready = (st_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign commit    = (st_q == ST_LOOKUP) && out_free;

	assign ram_we    = (st_q == ST_CLEAR) || commit;
	assign ram_waddr = (st_q == ST_CLEAR) ? clr_q : set_s1;
	assign ram_wdata = (st_q == ST_CLEAR) ? '0 : row_new;

	salru_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (set_in),
		.rdata (ram_rdata)
	);

	// Unpack the set row; a row holds {valid, tag, age} per way, way 0 lowest.
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			vld[w]    = ram_rdata[w*LINE_W + LINE_W - 1];
			tags[w]   = ram_rdata[w*LINE_W + AGE_W +: ADDR_WIDTH];
			ages[w]   = ram_rdata[w*LINE_W +: AGE_W];
			in_use[w] = NW_W'(w) < nw_eff;
		end
	end

	// Lowest matching way, lowest empty way, and the oldest way (lowest on a tie).
	always_comb begin
		hit        = 1'b0;
		hit_way    = '0;
		empty      = 1'b0;
		empty_way  = '0;
		victim_way = '0;
		victim_age = ages[0];
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (in_use[w] && vld[w] && (tags[w] == tag_s1)) begin
				hit     = 1'b1;
				hit_way = WAY_IDX_W'(w);
			end
			if (in_use[w] && !vld[w]) begin
				empty     = 1'b1;
				empty_way = WAY_IDX_W'(w);
			end
		end
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && (ages[w] > victim_age)) begin
				victim_way = WAY_IDX_W'(w);
				victim_age = ages[w];
			end
		end
	end

	assign touched_way = hit ? hit_way : (empty ? empty_way : victim_way);
	assign age_limit   = hit ? {1'b0, ages[hit_way]} : LIM_W'(1 << AGE_W);

	// The touched way becomes most recent; younger valid ways in use age by one.
	always_comb begin
		row_new = ram_rdata;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_IDX_W'(w) == touched_way) begin
				row_new[w*LINE_W +: LINE_W] = {1'b1, tag_s1, {AGE_W{1'b0}}};
			end else if (in_use[w] && vld[w] && ({1'b0, ages[w]} < age_limit) &&
					(ages[w] != salru_pkg::AGE_MAX)) begin
				row_new[w*LINE_W +: AGE_W] = ages[w] + AGE_W'(1);
			end
		end
	end

	// A modify adds one more hit for its second access.
	assign hit_inc    = 2'(hit) + 2'(modify_s1);
	assign hits_sum   = {1'b0, hits_q} + (COUNT_W + 1)'(hit_inc);
	assign misses_sum = {1'b0, misses_q} + (COUNT_W + 1)'(!hit);
	assign evicts_sum = {1'b0, evicts_q} + (COUNT_W + 1)'(!hit && !empty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= salru_pkg::SET_BITS_RST;
			ways_q       <= salru_pkg::WAYS_RST;
			block_bits_q <= salru_pkg::BLOCK_BITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				salru_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_data[salru_pkg::SET_BITS_W-1:0];
				salru_pkg::CFG_WAYS:       ways_q       <= cfg_data[salru_pkg::WAYS_W-1:0];
				salru_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == {SET_W{1'b1}}) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (commit) begin
				rsp_valid_q <= 1'b1;
				hits_q      <= hits_sum[COUNT_W] ? '1 : hits_sum[COUNT_W-1:0];
				misses_q    <= misses_sum[COUNT_W] ? '1 : misses_sum[COUNT_W-1:0];
				evicts_q    <= evicts_sum[COUNT_W] ? '1 : evicts_sum[COUNT_W-1:0];
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1    <= set_in;
			tag_s1    <= tag_in;
			modify_s1 <= (req.action == salru_pkg::ACT_MODIFY);
		end
		if (commit) begin
			outcome_q    <= hit ? salru_pkg::OUT_HIT :
				(empty ? salru_pkg::OUT_MISS : salru_pkg::OUT_EVICT);
			second_hit_q <= modify_s1;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.outcome     = outcome_q;
	assign rsp.second_hit  = second_hit_q;
	assign rsp.hit_total   = hits_q;
	assign rsp.miss_total  = misses_q;
	assign rsp.evict_total = evicts_q;

	`SALRU_ASSERT_NXT(a_accept_to_lookup, accept, st_q == ST_LOOKUP)
	`SALRU_ASSERT_IMP(a_result_from_lookup, $rose(rsp_valid_q), $past(st_q) == ST_LOOKUP)
	`SALRU_ASSERT_IMP(a_touch_in_use, commit, NW_W'(touched_way) < nw_eff)
	`SALRU_ASSERT_NXT(a_hits_monotonic, st_q != ST_CLEAR, hits_q >= $past(hits_q))
endmodule

/* hw/rtl/salru_ram.sv */
// Simple dual-port RAM with one write port and a registered read port.
module salru_ram #(
	parameter int WIDTH = salru_pkg::ADDR_WIDTH_DEF,
	parameter int DEPTH = 1 << salru_pkg::MAX_SET_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* sim/tb_set_assoc_cache_lru_sim.sv */
// Testbench of the LRU cache tag store: directed and random accesses checked by a predictor.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_sim;
	// Action 3 has no meaning of its own and must behave as a load.
	localparam logic [salru_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;
	// Index 3 selects no register, so a write there must change nothing.
	localparam logic [salru_pkg::CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;
	localparam int LINE_COUNT = (1 << salru_pkg::MAX_SET_BITS_DEF) * salru_pkg::MAX_WAYS_DEF;
	localparam int SEG_ITEMS = 64;
	localparam int SEGS_PER_PHASE = 6;

	typedef struct packed {
		logic [salru_pkg::OUTCOME_W-1:0] outcome;
		logic                            second_hit;
		logic [salru_pkg::COUNT_W-1:0]   hits;
		logic [salru_pkg::COUNT_W-1:0]   misses;
		logic [salru_pkg::COUNT_W-1:0]   evicts;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [salru_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [salru_pkg::CFG_DATA_W-1:0] cfg_data;

	salru_req_if req_ch ();
	salru_rsp_if rsp_ch ();

	set_assoc_cache_lru_sim dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the registers and the tag store.
	logic [salru_pkg::SET_BITS_W-1:0] cur_set_bits;
	logic [salru_pkg::WAYS_W-1:0] cur_ways;
	logic [salru_pkg::BLOCK_BITS_W-1:0] cur_block_bits;
	bit line_ok [LINE_COUNT];
	logic [salru_pkg::ADDRESS_W-1:0] line_tag_copy [LINE_COUNT];
	logic [salru_pkg::AGE_W-1:0] line_rank [LINE_COUNT];
	logic [salru_pkg::COUNT_W-1:0] hit_count;
	logic [salru_pkg::COUNT_W-1:0] miss_count;
	logic [salru_pkg::COUNT_W-1:0] evict_count;

	access_result_t pending_results[$];
	access_result_t oldest_expected;
	logic [salru_pkg::ADDRESS_W-1:0] tag_pool[$];
	int send_gap_pct;
	int recv_stall_pct;
	int fail_count;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [salru_pkg::COUNT_W-1:0] sat_inc(
		input logic [salru_pkg::COUNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic int active_set_bits();
		return (cur_set_bits > salru_pkg::MAX_SET_BITS_DEF) ? salru_pkg::MAX_SET_BITS_DEF :
			int'(cur_set_bits);
	endfunction

	function automatic int active_ways();
		if (cur_ways == 0)
			return 1;
		return (cur_ways > salru_pkg::MAX_WAYS_DEF) ? salru_pkg::MAX_WAYS_DEF : int'(cur_ways);
	endfunction

	// Valid lines in use younger than limit grow one step older, except the skipped way.
	function automatic void age_lines(input int base, input int nw, input int skip,
		input int limit);
		int w;
		for (w = 0; w < nw; w++) begin
			if (w != skip && line_ok[base + w] && line_rank[base + w] < limit &&
				line_rank[base + w] != salru_pkg::AGE_MAX)
				line_rank[base + w] = line_rank[base + w] + 1'b1;
		end
	endfunction

	function automatic logic [salru_pkg::OUTCOME_W-1:0] lookup(
		input logic [salru_pkg::ADDRESS_W-1:0] addr);
		int sb;
		int nw;
		int base;
		int w;
		int victim;
		logic [salru_pkg::ADDRESS_W-1:0] tag;
		sb = active_set_bits();
		nw = active_ways();
		base = int'((addr >> cur_block_bits) & ((64'd1 << sb) - 64'd1)) *
			salru_pkg::MAX_WAYS_DEF;
		tag = addr >> (cur_block_bits + sb);
		for (w = 0; w < nw; w++) begin
			if (line_ok[base + w] && line_tag_copy[base + w] == tag) begin
				age_lines(base, nw, w, int'(line_rank[base + w]));
				line_rank[base + w] = '0;
				hit_count = sat_inc(hit_count);
				return salru_pkg::OUT_HIT;
			end
		end
		miss_count = sat_inc(miss_count);
		for (w = 0; w < nw; w++) begin
			if (!line_ok[base + w]) begin
				age_lines(base, nw, w, int'(salru_pkg::AGE_MAX) + 1);
				line_ok[base + w] = 1'b1;
				line_tag_copy[base + w] = tag;
				line_rank[base + w] = '0;
				return salru_pkg::OUT_MISS;
			end
		end
		evict_count = sat_inc(evict_count);
		victim = 0;
		for (w = 1; w < nw; w++) begin
			if (line_rank[base + w] > line_rank[base + victim])
				victim = w;
		end
		age_lines(base, nw, victim, int'(salru_pkg::AGE_MAX) + 1);
		line_tag_copy[base + victim] = tag;
		line_rank[base + victim] = '0;
		return salru_pkg::OUT_EVICT;
	endfunction

	function automatic access_result_t predict_item(
		input logic [salru_pkg::ACTION_W-1:0] action,
		input logic [salru_pkg::ADDRESS_W-1:0] addr);
		access_result_t r;
		r.outcome = lookup(addr);
		r.second_hit = 1'b0;
		if (action == salru_pkg::ACT_MODIFY)
			r.second_hit = (lookup(addr) == salru_pkg::OUT_HIT);
		r.hits = hit_count;
		r.misses = miss_count;
		r.evicts = evict_count;
		return r;
	endfunction

	// Addresses mostly come from a small pool of tags over a few sets, so that hits,
	// fills and evictions all happen often; one in ten is a fully random address.
	function automatic logic [salru_pkg::ADDRESS_W-1:0] pick_address();
		int sb;
		logic [salru_pkg::ADDRESS_W-1:0] set_idx;
		logic [salru_pkg::ADDRESS_W-1:0] offset;
		if ($urandom_range(0, 9) == 0)
			return {$urandom, $urandom};
		sb = active_set_bits();
		set_idx = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} :
			64'($urandom_range(0, 3));
		offset = {$urandom, $urandom};
		return (tag_pool[$urandom_range(0, tag_pool.size() - 1)] << (cur_block_bits + sb))
			| ((set_idx & ((64'd1 << sb) - 64'd1)) << cur_block_bits)
			| (offset & ((64'd1 << cur_block_bits) - 64'd1));
	endfunction

	task automatic send_access(input logic [salru_pkg::ACTION_W-1:0] action,
		input logic [salru_pkg::ADDRESS_W-1:0] addr);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= action;
		req_ch.address <= addr;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_results.push_back(predict_item(action, addr));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [salru_pkg::CFG_IDX_W-1:0] idx,
		input logic [salru_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			salru_pkg::CFG_SET_BITS: begin
				cur_set_bits = data[salru_pkg::SET_BITS_W-1:0];
			end
			salru_pkg::CFG_WAYS: begin
				cur_ways = data[salru_pkg::WAYS_W-1:0];
			end
			salru_pkg::CFG_BLOCK_BITS: begin
				cur_block_bits = data;
			end
			default: begin
			end
		endcase
	endtask

	// Writes all three registers once the block is idle and draws a new tag pool.
	task automatic configure(input logic [salru_pkg::SET_BITS_W-1:0] sb,
		input logic [salru_pkg::WAYS_W-1:0] nw,
		input logic [salru_pkg::BLOCK_BITS_W-1:0] bb);
		bit pad_bit;
		bit fill_bit;
		wait_drained();
		pad_bit = 1'($urandom_range(0, 1));
		cfg_write(salru_pkg::CFG_SET_BITS, {pad_bit, sb});
		pad_bit = 1'($urandom_range(0, 1));
		cfg_write(salru_pkg::CFG_WAYS, {pad_bit, nw});
		cfg_write(salru_pkg::CFG_BLOCK_BITS, bb);
		tag_pool.delete();
		repeat (active_ways() + $urandom_range(1, 3))
			tag_pool.push_back({$urandom, $urandom});
		if ($urandom_range(0, 1) == 1) begin
			fill_bit = 1'($urandom_range(0, 1));
			tag_pool[0] = {salru_pkg::ADDRESS_W{fill_bit}};
		end
	endtask

	task automatic test_reset_defaults();
		// Reset setting: 16 sets, one way, 16-byte blocks.
		send_access(salru_pkg::ACT_LOAD, 64'h0);
		send_access(salru_pkg::ACT_LOAD, 64'h8);
		send_access(salru_pkg::ACT_STORE, 64'h0);
		send_access(salru_pkg::ACT_MODIFY, 64'h100);
		send_access(ACT_RESERVED, 64'h100);
		send_access(salru_pkg::ACT_MODIFY, 64'h100);
		send_access(salru_pkg::ACT_LOAD, '1);
		send_access(salru_pkg::ACT_STORE, '1);
		send_access(salru_pkg::ACT_LOAD, 64'h8000_0000_0000_00F0);
	endtask

	task automatic test_lru_order();
		// Two ways, two sets, 2-byte blocks: tags 0, 1, 2 at addresses 0, 4, 8.
		configure(4'd1, 4'd2, 5'd1);
		send_access(salru_pkg::ACT_LOAD, 64'h0);
		send_access(salru_pkg::ACT_LOAD, 64'h4);
		send_access(salru_pkg::ACT_STORE, 64'h0);
		send_access(salru_pkg::ACT_LOAD, 64'h8);
		send_access(salru_pkg::ACT_MODIFY, 64'h4);
		send_access(salru_pkg::ACT_LOAD, 64'h0);
	endtask

	task automatic test_config_extremes();
		// Values above the limits are clamped to 10 set bits and 8 ways.
		configure(4'd15, 4'd15, 5'd31);
		send_access(salru_pkg::ACT_LOAD, '1);
		send_access(salru_pkg::ACT_LOAD, 64'h0);
		send_access(salru_pkg::ACT_MODIFY, 64'h8000_0000_0000_0000);
		// One set, one way, no offset: the whole address is the tag, bit 63 included.
		configure(4'd0, 4'd0, 5'd0);
		send_access(salru_pkg::ACT_LOAD, 64'h0);
		send_access(salru_pkg::ACT_LOAD, 64'h8000_0000_0000_0000);
		send_access(salru_pkg::ACT_LOAD, 64'h0);
		send_access(salru_pkg::ACT_MODIFY, '1);
		wait_drained();
		cfg_write(CFG_RESERVED, '1);
		send_access(salru_pkg::ACT_LOAD, 64'h8000_0000_0000_0000);
	endtask

	task automatic test_random_traffic();
		int phase;
		int seg;
		int n;
		logic [salru_pkg::SET_BITS_W-1:0] sb;
		logic [salru_pkg::WAYS_W-1:0] nw;
		logic [salru_pkg::BLOCK_BITS_W-1:0] bb;
		logic [salru_pkg::ACTION_W-1:0] act;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 7;
					recv_stall_pct = 82;
				end
				1: begin
					send_gap_pct = 82;
					recv_stall_pct = 7;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (seg = 0; seg < SEGS_PER_PHASE; seg++) begin
				if (seg == 0) begin
					sb = salru_pkg::SET_BITS_W'(salru_pkg::MAX_SET_BITS_DEF);
					nw = salru_pkg::WAYS_W'(salru_pkg::MAX_WAYS_DEF);
					bb = 5'd16;
				end else if (seg == 1) begin
					sb = 4'd1;
					nw = 4'd1;
					bb = 5'd1;
				end else begin
					sb = salru_pkg::SET_BITS_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 15) :
						$urandom_range(1, salru_pkg::MAX_SET_BITS_DEF));
					nw = salru_pkg::WAYS_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 15) :
						$urandom_range(1, salru_pkg::MAX_WAYS_DEF));
					bb = salru_pkg::BLOCK_BITS_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 31) : $urandom_range(1, 16));
				end
				configure(sb, nw, bb);
				for (n = 0; n < SEG_ITEMS; n++) begin
					// Halfway through, let every outstanding result come back first.
					if (n == SEG_ITEMS / 2)
						wait_drained();
					act = salru_pkg::ACTION_W'($urandom_range(0, 3));
					send_access(act, pick_address());
				end
			end
		end
	endtask

	function automatic void compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result item with no access outstanding");
				fail_count++;
			end else begin
				oldest_expected = pending_results.pop_front();
				compare_field("outcome", oldest_expected.outcome, rsp_ch.outcome);
				compare_field("second_hit", oldest_expected.second_hit, rsp_ch.second_hit);
				compare_field("hit_total", oldest_expected.hits, rsp_ch.hit_total);
				compare_field("miss_total", oldest_expected.misses, rsp_ch.miss_total);
				compare_field("evict_total", oldest_expected.evicts, rsp_ch.evict_total);
			end
		end
	end

	initial begin
		int drain_cycles;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = salru_pkg::ACT_LOAD;
		req_ch.address = '0;
		cur_set_bits = salru_pkg::SET_BITS_RST;
		cur_ways = salru_pkg::WAYS_RST;
		cur_block_bits = salru_pkg::BLOCK_BITS_RST;
		foreach (line_ok[i])
			line_ok[i] = 1'b0;
		hit_count = '0;
		miss_count = '0;
		evict_count = '0;
		fail_count = 0;
		send_gap_pct = 7;
		recv_stall_pct = 82;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_lru_order();
		test_config_extremes();
		test_random_traffic();

		stop_sending();
		for (drain_cycles = 0; drain_cycles < 20000 && pending_results.size() != 0;
			drain_cycles++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected result items never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("tb_set_assoc_cache_lru_sim: PASS");
		end else begin
			$display("tb_set_assoc_cache_lru_sim: FAIL");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("tb_set_assoc_cache_lru_sim: FAIL");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/salru_pkg.sv
hw/rtl/salru_if.sv
hw/rtl/salru_ram.sv
hw/rtl/set_assoc_cache_lru_sim.sv
sim/tb_set_assoc_cache_lru_sim.sv
